// ===== rtl/core/crcfr_pkg.sv =====
// Package for the CRC-checked frame receiver.
// Holds opcodes, phase type, reply codes, the queue command record and the CRC-16/ARC step.
// No dependencies.
package crcfr_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned OPCODE_W     = 2;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned READ_INDEX_W = 9;
  localparam int unsigned CRC_W        = 16;

  // Decoupling queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Item opcodes.
  typedef enum logic [OPCODE_W-1:0] {
    OP_BYTE    = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_READ    = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_t;

  // Receiver phase.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_CRC  = 2'd2
  } phase_t;

  // Start bytes and reply codes.
  localparam logic [BYTE_W-1:0] START_UPPER   = 8'hD0;
  localparam logic [BYTE_W-1:0] START_LOWER   = 8'hD1;
  localparam logic [BYTE_W-1:0] REPLY_UPPER   = 8'hA0;
  localparam logic [BYTE_W-1:0] REPLY_LOWER   = 8'hA1;
  localparam logic [BYTE_W-1:0] REPLY_OK_UPPR = 8'hAA;
  localparam logic [BYTE_W-1:0] REPLY_OK_LOWR = 8'hAB;

  // Reflected CRC-16/ARC polynomial.
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  // Classified command handed from the front part to the back part.
  typedef struct packed {
    logic              reply_valid;
    logic [BYTE_W-1:0] reply_byte;
    logic              frame_done;
    logic              crc_ok;
    logic              lower_half;
    logic              wr_en;
    logic              rd_en;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  // One byte of CRC-16/ARC, bit by bit, LSB first.
  function automatic logic [CRC_W-1:0] crc16_arc_byte(input logic [CRC_W-1:0] crc_in,
                                                      input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/crcfr_in_if.sv =====
// Input channel interface of the frame receiver: valid, ready and one input item.
// Depends on crcfr_pkg.
interface crcfr_in_if
  import crcfr_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [OPCODE_W-1:0]     opcode;
  logic [BYTE_W-1:0]       rx_byte;
  logic [READ_INDEX_W-1:0] read_index;

  modport source (output valid, output opcode, output rx_byte, output read_index,
                  input ready);
  modport sink (input valid, input opcode, input rx_byte, input read_index,
                output ready);
endinterface

// ===== rtl/core/crcfr_out_if.sv =====
// Result channel interface of the frame receiver: valid, ready and one result item.
// Depends on crcfr_pkg.
interface crcfr_out_if
  import crcfr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              reply_valid;
  logic [BYTE_W-1:0] reply_byte;
  logic              frame_done;
  logic              crc_ok;
  logic              lower_half;
  logic [BYTE_W-1:0] read_data;

  modport source (output valid, output reply_valid, output reply_byte, output frame_done,
                  output crc_ok, output lower_half, output read_data, input ready);
  modport sink (input valid, input reply_valid, input reply_byte, input frame_done,
                input crc_ok, input lower_half, input read_data, output ready);
endinterface

// ===== rtl/core/crc_checked_frame_receiver_unit.sv =====
// Top level of the CRC-checked frame receiver: front, command queue and back parts.
// Depends on crcfr_pkg, crcfr_in_if, crcfr_out_if, crcfr_front, crcfr_queue, crcfr_back.
//
//   Channel | Direction | Handshake     | Carries
//   in_ch   | sink      | valid / ready | opcode, rx_byte, read_index
//   out_ch  | source    | valid / ready | reply_valid, reply_byte, frame_done, crc_ok,
//           |           |               | lower_half, read_data
//
// One item is accepted per cycle while the queue has room; each gives one result, passing
// through the command queue and then the buffer access and output register.
// The CRC byte update runs in the front part within the accept cycle.
// Reset is synchronous and active low; it clears the protocol state, the queue and the
// output valid. The frame buffer is not cleared.
// When out_ch stalls, the two-entry queue fills and then in_ch.ready drops.
module crc_checked_frame_receiver_unit
  import crcfr_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 400
) (
  input  logic         clk,
  input  logic         rst_n,
  crcfr_in_if.sink     in_ch,
  crcfr_out_if.source  out_ch
);

  localparam int unsigned ADDR_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int unsigned CNT_W  = $clog2(FRAME_BYTES + 1);

  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  cmd_t              push_cmd;
  cmd_t              head_cmd;
  logic [ADDR_W-1:0] push_addr;
  logic [ADDR_W-1:0] head_addr;

  // Front part: protocol, CRC and classification.
  crcfr_front #(
    .FRAME_BYTES (FRAME_BYTES),
    .ADDR_W      (ADDR_W),
    .CNT_W       (CNT_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_addr (push_addr)
  );

  // Command queue between the two parts.
  crcfr_queue #(
    .ADDR_W (ADDR_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_addr (push_addr),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head_cmd  (head_cmd),
    .head_addr (head_addr)
  );

  // Back part: frame buffer and output register.
  crcfr_back #(
    .FRAME_BYTES (FRAME_BYTES),
    .ADDR_W      (ADDR_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (q_empty),
    .head_cmd  (head_cmd),
    .head_addr (head_addr),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

// ===== rtl/core/crcfr_front.sv =====
// Front part of the frame receiver: accepts items, runs the frame protocol and CRC,
// and classifies each item into a command for the back part. Depends on crcfr_pkg, crcfr_in_if.
module crcfr_front
  import crcfr_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 400,
  parameter int unsigned ADDR_W      = 9,
  parameter int unsigned CNT_W       = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  crcfr_in_if.sink          in_ch,
  input  logic              q_full,
  output logic              push,
  output cmd_t              push_cmd,
  output logic [ADDR_W-1:0] push_addr
);

  phase_t            phase_r, phase_nxt;
  logic              half_r, half_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  count_inc;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [BYTE_W-1:0] remote_hi_r, remote_hi_nxt;
  logic              hi_seen_r, hi_seen_nxt;
  opcode_t           op;

  // Accept whenever the queue has room.
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && in_ch.ready;
  assign op          = opcode_t'(in_ch.opcode);
  assign count_inc   = count_r + CNT_W'(1);

  // Protocol state update and command classification.
  always_comb begin
    phase_nxt     = phase_r;
    half_nxt      = half_r;
    count_nxt     = count_r;
    crc_nxt       = crc_r;
    remote_hi_nxt = remote_hi_r;
    hi_seen_nxt   = hi_seen_r;
    push_cmd      = '0;
    push_addr     = '0;

    unique case (op)
      OP_BYTE: begin
        unique case (phase_r)
          PH_IDLE: begin
            if (in_ch.rx_byte == START_UPPER || in_ch.rx_byte == START_LOWER) begin
              half_nxt             = (in_ch.rx_byte == START_LOWER);
              count_nxt            = '0;
              crc_nxt              = '0;
              hi_seen_nxt          = 1'b0;
              phase_nxt            = PH_DATA;
              push_cmd.reply_valid = 1'b1;
              push_cmd.reply_byte  = half_nxt ? REPLY_LOWER : REPLY_UPPER;
            end
          end
          PH_DATA: begin
            push_cmd.wr_en = 1'b1;
            push_cmd.data  = in_ch.rx_byte;
            push_addr      = ADDR_W'(count_r);
            crc_nxt        = crc16_arc_byte(crc_r, in_ch.rx_byte);
            if (count_inc == CNT_W'(FRAME_BYTES)) begin
              phase_nxt   = PH_CRC;
              count_nxt   = '0;
              hi_seen_nxt = 1'b0;
            end else begin
              count_nxt = count_inc;
            end
          end
          PH_CRC: begin
            if (!hi_seen_r) begin
              remote_hi_nxt = in_ch.rx_byte;
              hi_seen_nxt   = 1'b1;
            end else begin
              push_cmd.frame_done = 1'b1;
              if ({remote_hi_r, in_ch.rx_byte} == crc_r) begin
                push_cmd.crc_ok      = 1'b1;
                push_cmd.reply_valid = 1'b1;
                push_cmd.reply_byte  = half_r ? REPLY_OK_LOWR : REPLY_OK_UPPR;
              end
              phase_nxt   = PH_IDLE;
              count_nxt   = '0;
              hi_seen_nxt = 1'b0;
            end
          end
          default: begin
            phase_nxt   = PH_IDLE;
            count_nxt   = '0;
            crc_nxt     = '0;
            hi_seen_nxt = 1'b0;
          end
        endcase
      end
      OP_TIMEOUT: begin
        phase_nxt   = PH_IDLE;
        count_nxt   = '0;
        crc_nxt     = '0;
        hi_seen_nxt = 1'b0;
      end
      OP_READ: begin
        if (32'(in_ch.read_index) < 32'(FRAME_BYTES)) begin
          push_cmd.rd_en = 1'b1;
          push_addr      = ADDR_W'(in_ch.read_index);
        end
      end
      default: begin
      end
    endcase

    push_cmd.lower_half = half_nxt;
  end

  // Protocol state registers, advanced on each transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      half_r      <= 1'b0;
      count_r     <= '0;
      crc_r       <= '0;
      remote_hi_r <= '0;
      hi_seen_r   <= 1'b0;
    end else if (push) begin
      phase_r     <= phase_nxt;
      half_r      <= half_nxt;
      count_r     <= count_nxt;
      crc_r       <= crc_nxt;
      remote_hi_r <= remote_hi_nxt;
      hi_seen_r   <= hi_seen_nxt;
    end
  end

  // A frame can only finish out of the CRC phase.
  a_done_from_crc: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_cmd.frame_done |-> phase_r == PH_CRC && hi_seen_r)
    else $error("frame done outside the CRC phase");

  // Buffer writes stay inside the frame buffer.
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_cmd.wr_en |-> phase_r == PH_DATA && 32'(count_r) < 32'(FRAME_BYTES))
    else $error("buffer write outside the data phase or the buffer");

endmodule

// ===== rtl/core/crcfr_queue.sv =====
// Two-entry command queue between the front and back parts of the frame receiver.
// Depends on crcfr_pkg.
module crcfr_queue
  import crcfr_pkg::*;
#(
  parameter int unsigned ADDR_W = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cmd_t              push_cmd,
  input  logic [ADDR_W-1:0] push_addr,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output cmd_t              head_cmd,
  output logic [ADDR_W-1:0] head_addr
);

  cmd_t                   cmd_q [QUEUE_DEPTH];
  logic [ADDR_W-1:0]      addr_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] count_r;

  assign full      = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign head_cmd  = cmd_q[rd_ptr_r];
  assign head_addr = addr_q[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q[wr_ptr_r]  <= push_cmd;
      addr_q[wr_ptr_r] <= push_addr;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QUEUE_CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("pop from an empty queue");

endmodule

// ===== rtl/core/crcfr_back.sv =====
// Back part of the frame receiver: owns the frame buffer, executes writes and reads,
// and holds the result in the output register. Depends on crcfr_pkg, crcfr_out_if.
module crcfr_back
  import crcfr_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 400,
  parameter int unsigned ADDR_W      = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              empty,
  input  cmd_t              head_cmd,
  input  logic [ADDR_W-1:0] head_addr,
  output logic              pop,
  crcfr_out_if.source       out_ch
);

  logic [BYTE_W-1:0] buf_mem [FRAME_BYTES];
  logic [BYTE_W-1:0] rd_data_r;
  cmd_t              cmd_r;
  logic              valid_r;

  // Take the next command when the output register is free or being drained.
  assign pop = !empty && (!valid_r || out_ch.ready);

  // Frame buffer: at most one write or one registered read per command.
  always_ff @(posedge clk) begin
    if (pop && head_cmd.wr_en) begin
      buf_mem[head_addr] <= head_cmd.data;
    end
    if (pop && head_cmd.rd_en) begin
      rd_data_r <= buf_mem[head_addr];
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= head_cmd;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.reply_valid = cmd_r.reply_valid;
  assign out_ch.reply_byte  = cmd_r.reply_byte;
  assign out_ch.frame_done  = cmd_r.frame_done;
  assign out_ch.crc_ok      = cmd_r.crc_ok;
  assign out_ch.lower_half  = cmd_r.lower_half;
  assign out_ch.read_data   = cmd_r.rd_en ? rd_data_r : '0;

  // A command is either a buffer write or a buffer read, never both.
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !(head_cmd.wr_en && head_cmd.rd_en))
    else $error("command both writes and reads the buffer");

endmodule
